@@ design/dqc_pkg.sv @@
// Package with the types and constants of the dual quaternion converter.
package dqc_pkg;

    typedef enum logic [1:0] {
        MODE_TO_DUAL   = 2'd0,
        MODE_FROM_UNIT = 2'd1,
        MODE_FROM_GEN  = 2'd2,
        MODE_NONE      = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]   mode;
        logic signed [15:0] real_w;
        logic signed [15:0] real_x;
        logic signed [15:0] real_y;
        logic signed [15:0] real_z;
        logic signed [31:0] dual_w;
        logic signed [31:0] dual_x;
        logic signed [31:0] dual_y;
        logic signed [31:0] dual_z;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } t_dqc_in;

    typedef struct packed {
        logic signed [15:0] out_real_w;
        logic signed [15:0] out_real_x;
        logic signed [15:0] out_real_y;
        logic signed [15:0] out_real_z;
        logic signed [31:0] out_dual_w;
        logic signed [31:0] out_dual_x;
        logic signed [31:0] out_dual_y;
        logic signed [31:0] out_dual_z;
        logic signed [31:0] out_trans_x;
        logic signed [31:0] out_trans_y;
        logic signed [31:0] out_trans_z;
        logic               zero_length;
    } t_dqc_out;

    // Saturate a wide signed value to 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] res;
        if (v > 64'sd32767) res = 16'sh7fff;
        else if (v < -64'sd32768) res = 16'sh8000;
        else res = v[15:0];
        return res;
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) res = 32'sh7fffffff;
        else if (v < -64'sd2147483648) res = 32'sh80000000;
        else res = v[31:0];
        return res;
    endfunction

    // Round a magnitude by a right shift, half away from zero, sign restored.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input logic [5:0] sh);
        logic [63:0] m;
        logic [63:0] r;
        m = v[63] ? 64'(-v) : 64'(v);
        r = (m + (64'd1 << (sh - 6'd1))) >> sh;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

endpackage

@@ design/dual_quat_conversion.sv @@
// Top level of the pipelined dual quaternion converter.
// Throughput: one transaction per cycle; busy is always low.
// The pipeline depth is set by the Newton steps for the inverse square root.
// Reset clears all valid bits of the pipeline; payload registers are not reset.
// The result is shown for one cycle on o_done and cannot be held off.
module dual_quat_conversion
    import dqc_pkg::*;
#(
    parameter int ROT_FRAC_BITS    = 14,
    parameter int RSQRT_ITERATIONS = 3
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_dqc_in  i_item,
    output logic     o_done,
    output t_dqc_out o_result
);

    localparam int NIT = RSQRT_ITERATIONS;
    localparam int DEP = 3 * NIT + 3;

    // Per-stage carried data.
    typedef struct packed {
        logic [1:0]          mode;
        logic signed [15:0]  r0, r1, r2, r3;
        logic signed [49:0]  s0, s1, s2, s3;
        logic                zero;
        logic signed [6:0]   k;
        logic [32:0]         x;
        logic [33:0]         y;
        logic [33:0]         tmp;
    } t_stage;

    logic       r_vld [DEP+1];
    t_stage     r_st  [DEP+1];
    t_stage     n_st0, n_st1;
    logic       r_done;
    t_dqc_out   r_res, n_res;

    assign busy = 1'b0;

    // Stage 0: products summed into the dual or translation sums, and |r|^2.
    logic signed [49:0] tx, ty, tz, dw, dx, dy, dz;
    logic signed [49:0] rw, rx, ry, rz;
    always_comb begin
        tx = 50'(i_item.trans_x); ty = 50'(i_item.trans_y); tz = 50'(i_item.trans_z);
        dw = 50'(i_item.dual_w);  dx = 50'(i_item.dual_x);
        dy = 50'(i_item.dual_y);  dz = 50'(i_item.dual_z);
        rw = 50'(i_item.real_w);  rx = 50'(i_item.real_x);
        ry = 50'(i_item.real_y);  rz = 50'(i_item.real_z);
        n_st0 = '0;
        n_st0.mode = i_item.mode;
        n_st0.r0 = i_item.real_w; n_st0.r1 = i_item.real_x;
        n_st0.r2 = i_item.real_y; n_st0.r3 = i_item.real_z;
        if (i_item.mode == MODE_TO_DUAL) begin
            n_st0.s0 = -(tx*rx + ty*ry + tz*rz);
            n_st0.s1 = tx*rw + ty*rz - tz*ry;
            n_st0.s2 = -tx*rz + ty*rw + tz*rx;
            n_st0.s3 = tx*ry - ty*rx + tz*rw;
        end else begin
            n_st0.s0 = -dw*rx + dx*rw - dy*rz + dz*ry;
            n_st0.s1 = -dw*ry + dx*rz + dy*rw - dz*rx;
            n_st0.s2 = -dw*rz - dx*ry + dy*rx + dz*rw;
            n_st0.s3 = '0;
        end
        n_st0.x = 33'(rw*rw + rx*rx + ry*ry + rz*rz);
    end

    // Stage 1: scale |r|^2 into [2^28, 2^30) and form the start value.
    logic [32:0] xs;
    always_comb begin
        n_st1 = r_st[0];
        n_st1.zero = (r_st[0].x == 33'd0);
        xs = r_st[0].x;
        n_st1.k = '0;
        if (r_st[0].x >= 33'h1_0000_0000) begin
            // Only the largest possible length lands here; two steps down.
            xs = r_st[0].x >> 4;
            n_st1.k = -7'sd2;
        end else if (r_st[0].x >= 33'h0_4000_0000) begin
            xs = r_st[0].x >> 2;
            n_st1.k = -7'sd1;
        end else begin
            // Even shift so that the top set bit lands at 28 or 29.
            for (int kk = 0; kk <= 14; kk++) begin
                if (r_st[0].x != 33'd0
                    && (64'(r_st[0].x) << (2*kk)) >= 64'h1000_0000
                    && (64'(r_st[0].x) << (2*kk)) < 64'h4000_0000) begin
                    xs = 33'(64'(r_st[0].x) << (2*kk));
                    n_st1.k = 7'(kk);
                end
            end
        end
        n_st1.x = xs;
        n_st1.y = 34'((34'd9 << 28) - 34'(xs) - 34'(xs >> 2));
    end

    // Control: valid bits advance every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= DEP; j++) r_vld[j] <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_vld[0] <= start;
            for (int j = 1; j <= DEP; j++) r_vld[j] <= r_vld[j-1];
            r_done <= r_vld[DEP];
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= n_st0;
        r_st[1] <= n_st1;
        r_res   <= n_res;
    end

    // Newton steps, three registered multiplies each.
    for (genvar g = 0; g < NIT; g++) begin : g_newton
        t_stage a, b, c;
        always_comb begin
            a = r_st[3*g+1];
            a.tmp = 34'((64'(a.y) * 64'(a.y)) >> 30);
            b = r_st[3*g+2];
            b.tmp = 34'((64'(b.x) * 64'(b.tmp)) >> 30);
            b.tmp = (b.tmp >= (34'd3 << 30)) ? 34'd0 : (34'd3 << 30) - b.tmp;
            c = r_st[3*g+3];
            c.y = 34'((64'(c.y) * 64'(c.tmp)) >> 31);
        end
        always_ff @(posedge i_clk) begin
            r_st[3*g+2] <= a;
            r_st[3*g+3] <= b;
            r_st[3*g+4] <= c;
        end
    end

    // Stage after the loop: scaled rotation; translation split in two parts.
    // Only a general dual quaternion is rescaled; other modes pass unchanged.
    t_stage e;
    logic [5:0] shr;
    logic [63:0] m0, m1, m2;
    always_comb begin
        e = r_st[DEP-2];
        shr = 6'(45 - ROT_FRAC_BITS - int'(e.k));
        m0 = e.s0[49] ? 64'(-e.s0) : 64'(e.s0);
        m1 = e.s1[49] ? 64'(-e.s1) : 64'(e.s1);
        m2 = e.s2[49] ? 64'(-e.s2) : 64'(e.s2);
        if (t_mode'(e.mode) == MODE_FROM_GEN) begin
            e.r0 = sat16(rnd_shift(64'(e.r0) * $signed({1'b0, e.y[31:0]}), shr));
            e.r1 = sat16(rnd_shift(64'(e.r1) * $signed({1'b0, e.y[31:0]}), shr));
            e.r2 = sat16(rnd_shift(64'(e.r2) * $signed({1'b0, e.y[31:0]}), shr));
            e.r3 = sat16(rnd_shift(64'(e.r3) * $signed({1'b0, e.y[31:0]}), shr));
            // Low partial products of the translation magnitudes.
            e.x = 33'(((m0 & 64'hFFFFFF) * 64'(e.y)) >> 24);
            e.s3 = 50'(((m1 & 64'hFFFFFF) * 64'(e.y)) >> 24);
            e.tmp = 34'(((m2 & 64'hFFFFFF) * 64'(e.y)) >> 24);
        end
    end
    always_ff @(posedge i_clk) begin
        r_st[DEP-1] <= e;
    end

    // High partial products and rounding of the translation.
    function automatic logic signed [31:0] tr_fin(input logic signed [49:0] p,
                                                  input logic [33:0] y,
                                                  input logic [63:0] lo,
                                                  input logic signed [6:0] k);
        logic [63:0] m, a, c;
        logic [5:0] s;
        m = p[49] ? 64'(-p) : 64'(p);
        s = 6'(44 - int'(k));
        a = (m >> 24) * 64'(y) + (64'd1 << (s - 6'd25));
        c = (a + lo) >> (s - 6'd24);
        return sat32(p[49] ? -$signed(c) : $signed(c));
    endfunction

    t_stage f;
    always_comb begin
        f = r_st[DEP-1];
        if (t_mode'(f.mode) == MODE_FROM_GEN) begin
            f.s0 = 50'(tr_fin(f.s0, f.y, 64'(f.x), f.k));
            f.s1 = 50'(tr_fin(f.s1, f.y, 64'(f.s3), f.k));
            f.s2 = 50'(tr_fin(f.s2, f.y, 64'(f.tmp), f.k));
        end
    end
    always_ff @(posedge i_clk) begin
        r_st[DEP] <= f;
    end

    // Result formatting. Modes 0 and 1 use the raw sums carried along.
    t_stage z;
    always_comb begin
        z = r_st[DEP];
        n_res = '0;
        unique case (t_mode'(z.mode))
            MODE_TO_DUAL: begin
                n_res.out_real_w = z.r0; n_res.out_real_x = z.r1;
                n_res.out_real_y = z.r2; n_res.out_real_z = z.r3;
                n_res.out_dual_w = sat32(rnd_shift(64'(z.s0), 6'(ROT_FRAC_BITS + 1)));
                n_res.out_dual_x = sat32(rnd_shift(64'(z.s1), 6'(ROT_FRAC_BITS + 1)));
                n_res.out_dual_y = sat32(rnd_shift(64'(z.s2), 6'(ROT_FRAC_BITS + 1)));
                n_res.out_dual_z = sat32(rnd_shift(64'(z.s3), 6'(ROT_FRAC_BITS + 1)));
            end
            MODE_FROM_UNIT: begin
                n_res.out_real_w = z.r0; n_res.out_real_x = z.r1;
                n_res.out_real_y = z.r2; n_res.out_real_z = z.r3;
                n_res.out_trans_x = sat32(rnd_shift(64'(z.s0), 6'(ROT_FRAC_BITS - 1)));
                n_res.out_trans_y = sat32(rnd_shift(64'(z.s1), 6'(ROT_FRAC_BITS - 1)));
                n_res.out_trans_z = sat32(rnd_shift(64'(z.s2), 6'(ROT_FRAC_BITS - 1)));
            end
            MODE_FROM_GEN: begin
                if (z.zero) begin
                    n_res.zero_length = 1'b1;
                end else begin
                    n_res.out_real_w = z.r0; n_res.out_real_x = z.r1;
                    n_res.out_real_y = z.r2; n_res.out_real_z = z.r3;
                    n_res.out_trans_x = z.s0[31:0];
                    n_res.out_trans_y = z.s1[31:0];
                    n_res.out_trans_z = z.s2[31:0];
                end
            end
            default: n_res = '0;
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

@@ tb/dual_quat_conversion_checker.sv @@
// Checker for the dual quaternion converter: predicts each result and compares it.
`timescale 1ns / 100ps
module dual_quat_conversion_checker
    import dqc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     busy,
    input  t_dqc_in  i_item,
    input  logic     o_done,
    input  t_dqc_out o_result,
    output int       o_fail_count,
    output int       o_pending
);

    localparam int ROT_FRAC = 14;
    localparam int NEWTON_STEPS = 3;

    t_dqc_out expected_results[$];
    int fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    // Clamp a wide value into a signed 16-bit field.
    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // Clamp a wide value into a signed 32-bit field.
    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Divide by a power of two, rounding the magnitude half away from zero.
    function automatic longint round_div_pow2(input longint v, input int sh);
        longint unsigned m;
        m = v < 0 ? -v : v;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    // Rounded P*y / 2^s, built in two halves so that nothing overflows 64 bits.
    function automatic longint scale_translation(input longint p, input longint unsigned y,
                                                 input int s);
        longint unsigned m, hi, lo, acc;
        m   = p < 0 ? -p : p;
        hi  = m >> 24;
        lo  = m & 64'hFFFFFF;
        acc = hi * y + (64'd1 << (s - 25)) + ((lo * y) >> 24);
        acc = acc >> (s - 24);
        return p < 0 ? -longint'(acc) : longint'(acc);
    endfunction

    // Compute the expected converter output for one input transaction.
    function automatic t_dqc_out convert_pose(input t_dqc_in it);
        t_dqc_out res;
        longint r[4], d[4], t[3], p[3], s[4];
        longint unsigned sq, x, y, y2, u, h;
        int k;
        res = '0;
        r[0] = it.real_w; r[1] = it.real_x; r[2] = it.real_y; r[3] = it.real_z;
        d[0] = it.dual_w; d[1] = it.dual_x; d[2] = it.dual_y; d[3] = it.dual_z;
        t[0] = it.trans_x; t[1] = it.trans_y; t[2] = it.trans_z;
        case (t_mode'(it.mode))
            MODE_TO_DUAL: begin
                s[0] = -(t[0] * r[1] + t[1] * r[2] + t[2] * r[3]);
                s[1] = t[0] * r[0] + t[1] * r[3] - t[2] * r[2];
                s[2] = -t[0] * r[3] + t[1] * r[0] + t[2] * r[1];
                s[3] = t[0] * r[2] - t[1] * r[1] + t[2] * r[0];
                res.out_real_w = it.real_w; res.out_real_x = it.real_x;
                res.out_real_y = it.real_y; res.out_real_z = it.real_z;
                res.out_dual_w = clamp32(round_div_pow2(s[0], ROT_FRAC + 1));
                res.out_dual_x = clamp32(round_div_pow2(s[1], ROT_FRAC + 1));
                res.out_dual_y = clamp32(round_div_pow2(s[2], ROT_FRAC + 1));
                res.out_dual_z = clamp32(round_div_pow2(s[3], ROT_FRAC + 1));
            end
            MODE_FROM_UNIT, MODE_FROM_GEN: begin
                p[0] = -d[0] * r[1] + d[1] * r[0] - d[2] * r[3] + d[3] * r[2];
                p[1] = -d[0] * r[2] + d[1] * r[3] + d[2] * r[0] - d[3] * r[1];
                p[2] = -d[0] * r[3] - d[1] * r[2] + d[2] * r[1] + d[3] * r[0];
                if (t_mode'(it.mode) == MODE_FROM_UNIT) begin
                    res.out_real_w = it.real_w; res.out_real_x = it.real_x;
                    res.out_real_y = it.real_y; res.out_real_z = it.real_z;
                    res.out_trans_x = clamp32(round_div_pow2(p[0], ROT_FRAC - 1));
                    res.out_trans_y = clamp32(round_div_pow2(p[1], ROT_FRAC - 1));
                    res.out_trans_z = clamp32(round_div_pow2(p[2], ROT_FRAC - 1));
                end else begin
                    sq = r[0] * r[0] + r[1] * r[1] + r[2] * r[2] + r[3] * r[3];
                    if (sq == 0) begin
                        res.zero_length = 1'b1;
                    end else begin
                        // Bring the squared length into [2^28, 2^30) by powers of four.
                        x = sq;
                        k = 0;
                        while (x < (64'd1 << 28)) begin
                            x = x << 2;
                            k++;
                        end
                        while (x >= (64'd1 << 30)) begin
                            x = x >> 2;
                            k--;
                        end
                        y = (64'd9 << 28) - x - (x >> 2);
                        // Newton steps towards the inverse square root.
                        for (int n = 0; n < NEWTON_STEPS; n++) begin
                            y2 = (y * y) >> 30;
                            u  = (x * y2) >> 30;
                            h  = u >= (64'd3 << 30) ? 64'd0 : (64'd3 << 30) - u;
                            y  = (y * h) >> 31;
                        end
                        res.out_real_w = clamp16(round_div_pow2(r[0] * longint'(y),
                                                                45 - ROT_FRAC - k));
                        res.out_real_x = clamp16(round_div_pow2(r[1] * longint'(y),
                                                                45 - ROT_FRAC - k));
                        res.out_real_y = clamp16(round_div_pow2(r[2] * longint'(y),
                                                                45 - ROT_FRAC - k));
                        res.out_real_z = clamp16(round_div_pow2(r[3] * longint'(y),
                                                                45 - ROT_FRAC - k));
                        res.out_trans_x = clamp32(scale_translation(p[0], y, 44 - k));
                        res.out_trans_y = clamp32(scale_translation(p[1], y, 44 - k));
                        res.out_trans_z = clamp32(scale_translation(p[2], y, 44 - k));
                    end
                end
            end
            default: res = '0;
        endcase
        return res;
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Compare each field of a result with its expectation.
    task automatic compare_result(input t_dqc_out got, input t_dqc_out want);
        if (got.out_real_w !== want.out_real_w)
            report_mismatch("out_real_w", got.out_real_w, want.out_real_w);
        if (got.out_real_x !== want.out_real_x)
            report_mismatch("out_real_x", got.out_real_x, want.out_real_x);
        if (got.out_real_y !== want.out_real_y)
            report_mismatch("out_real_y", got.out_real_y, want.out_real_y);
        if (got.out_real_z !== want.out_real_z)
            report_mismatch("out_real_z", got.out_real_z, want.out_real_z);
        if (got.out_dual_w !== want.out_dual_w)
            report_mismatch("out_dual_w", got.out_dual_w, want.out_dual_w);
        if (got.out_dual_x !== want.out_dual_x)
            report_mismatch("out_dual_x", got.out_dual_x, want.out_dual_x);
        if (got.out_dual_y !== want.out_dual_y)
            report_mismatch("out_dual_y", got.out_dual_y, want.out_dual_y);
        if (got.out_dual_z !== want.out_dual_z)
            report_mismatch("out_dual_z", got.out_dual_z, want.out_dual_z);
        if (got.out_trans_x !== want.out_trans_x)
            report_mismatch("out_trans_x", got.out_trans_x, want.out_trans_x);
        if (got.out_trans_y !== want.out_trans_y)
            report_mismatch("out_trans_y", got.out_trans_y, want.out_trans_y);
        if (got.out_trans_z !== want.out_trans_z)
            report_mismatch("out_trans_z", got.out_trans_z, want.out_trans_z);
        if (got.zero_length !== want.zero_length)
            report_mismatch("zero_length", got.zero_length, want.zero_length);
    endtask

    // Watch both channels at each rising edge; results are checked before new
    // expectations are queued, since a transaction cannot finish in its own cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transaction with nothing expected", $realtime);
                    fail_count++;
                end else begin
                    compare_result(o_result, expected_results.pop_front());
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                expected_results.push_back(convert_pose(i_item));
        end
    end

endmodule

@@ tb/dual_quat_conversion_test.sv @@
// Top of the converter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module dual_quat_conversion_test;
    import dqc_pkg::*;

    localparam int LATENCY = 4 + 3 * 3;
    localparam int IDLE_LIMIT = 2000;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_dqc_in  i_item;
    logic     o_done;
    t_dqc_out o_result;
    int       fail_count;
    int       pending;
    int       idle_cycles;
    int       gap_percent;

    dual_quat_conversion uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    dual_quat_conversion_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .o_done       (o_done),
        .o_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: ends the run after too many cycles without any transaction.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((start && !busy) || o_done) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Random 16-bit value, often pushed to an extreme.
    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random 32-bit value, mostly of modest size so that results do not all saturate.
    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 9))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h00000000;
            3, 4: return $urandom;
            default: return 32'($signed(20'($urandom)));
        endcase
    endfunction

    // Random transaction: mostly valid modes, sometimes a near-unit or zero rotation.
    function automatic t_dqc_in random_item();
        t_dqc_in it;
        it.mode = $urandom_range(0, 15) == 0 ? MODE_NONE : 2'($urandom_range(0, 2));
        it.real_w = pick16(); it.real_x = pick16();
        it.real_y = pick16(); it.real_z = pick16();
        if ($urandom_range(0, 9) == 0) begin
            it.real_w = 0; it.real_x = 0; it.real_y = 0; it.real_z = 0;
        end else if ($urandom_range(0, 3) == 0) begin
            it.real_w = 16'sd16384; it.real_x = 16'($signed(8'($urandom)));
        end
        it.dual_w = pick32(); it.dual_x = pick32(); it.dual_y = pick32(); it.dual_z = pick32();
        it.trans_x = pick32(); it.trans_y = pick32(); it.trans_z = pick32();
        return it;
    endfunction

    // Present one transaction and hold it until it is accepted, idling first at random.
    task automatic send_item(input t_dqc_in it);
        while ($urandom_range(0, 99) < gap_percent) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_item <= it;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        t_dqc_in it;
        start   = 1'b0;
        i_item  = '0;
        i_rst_n = 1'b0;
        gap_percent = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: every mode, the field extremes and the zero-length case.
        for (int m = 0; m < 4; m++) begin
            it = '0;
            it.mode = 2'(m);
            it.real_w = 16'sd16384;
            it.dual_x = 32'sd65536; it.trans_x = 32'sd65536;
            send_item(it);
            it = '1;
            it.mode = 2'(m);
            send_item(it);
            it.real_w = 16'sh8000; it.real_x = 16'sh8000; it.real_y = 16'sh8000;
            it.real_z = 16'sh8000;
            it.dual_w = 32'sh80000000; it.dual_x = 32'sh7fffffff;
            it.dual_y = 32'sh80000000; it.dual_z = 32'sh7fffffff;
            it.trans_x = 32'sh7fffffff; it.trans_y = 32'sh80000000;
            it.trans_z = 32'sh7fffffff;
            send_item(it);
            it.real_w = 0; it.real_x = 0; it.real_y = 0; it.real_z = 0;
            send_item(it);
            it.real_w = 16'sh7fff; it.real_z = 16'sd1;
            send_item(it);
        end

        // Random part, in phases of sender idling.
        for (int n = 0; n < 550; n++) begin
            case (n / 110)
                0: gap_percent = 0;
                1: gap_percent = 72;
                2: gap_percent = 21;
                3: gap_percent = 0;
                default: gap_percent = $urandom_range(0, 1) ? 72 : 0;
            endcase
            send_item(random_item());
        end
        start <= 1'b0;

        // Drain the pipeline, then allow a margin for stray results.
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/dqc_pkg.sv
design/dual_quat_conversion.sv
tb/dual_quat_conversion_checker.sv
tb/dual_quat_conversion_test.sv
